/* src/e2p_pkg.sv */
// Shared types, constants and width helpers for the equirectangular coordinate map.
package e2p_pkg;

  localparam int CFG_DIM_W  = 13;
  localparam int FOCAL_W    = 32;
  localparam int ROW_W      = 48;
  localparam int COEF_W     = 16;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  // normalized ray components do not exceed 2^NORM_BITS in magnitude
  localparam int NORM_BITS = 30;
  localparam int NW        = NORM_BITS + 1;

  // CORDIC datapath and angle widths (angles in binary turns, 2^32 per turn)
  localparam int CW = 36;
  localparam int AW = 34;

  localparam int OUT_W    = 21;
  localparam int ATAN_LEN = 24;

  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // CORDIC gain correction, Q30
  localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH  = 3'd0,
    REG_OUT_HEIGHT = 3'd1,
    REG_INV_FOCAL  = 3'd2,
    REG_ROT_ROW0   = 3'd3,
    REG_ROT_ROW1   = 3'd4,
    REG_ROT_ROW2   = 3'd5,
    REG_SRC_WIDTH  = 3'd6,
    REG_SRC_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic signed [CW-1:0] aux;
  } cordic_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] out_width;
    logic [CFG_DIM_W-1:0] out_height;
    logic [FOCAL_W-1:0]   inv_focal;
    logic [ROW_W-1:0]     rot_row0;
    logic [ROW_W-1:0]     rot_row1;
    logic [ROW_W-1:0]     rot_row2;
  } ray_cfg_t;

  // width of the doubled centre offset
  function automatic int offset_width(int dim_w);
    return (dim_w + 2 > CFG_DIM_W + 1) ? dim_w + 2 : CFG_DIM_W + 1;
  endfunction

  // width of the camera ray components
  function automatic int ray_width(int dim_w);
    return offset_width(dim_w) + FOCAL_W;
  endfunction

  // width of the rotated ray components
  function automatic int sum_width(int dim_w);
    return ray_width(dim_w) + COEF_W + 1;
  endfunction

endpackage

/* src/e2p_ray.sv */
// Camera ray generation and rotation by the configured matrix.
module e2p_ray import e2p_pkg::*; #(
  parameter int DIM_W = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [DIM_W-1:0]                       pixel_row,
  input  logic [DIM_W-1:0]                       pixel_col,
  input  ray_cfg_t                               cfg,
  output logic                                   out_valid,
  output logic signed [sum_width(DIM_W)-1:0]     wx,
  output logic signed [sum_width(DIM_W)-1:0]     wy,
  output logic signed [sum_width(DIM_W)-1:0]     wz
);

  localparam int D_W    = offset_width(DIM_W);
  localparam int RAY_W  = ray_width(DIM_W);
  localparam int PROD_W = RAY_W + COEF_W;
  localparam int WW     = sum_width(DIM_W);

  logic [2:0] vld;

  logic signed [D_W-1:0]   dx, dy;
  logic signed [RAY_W:0]   cx_full, cy_full;
  logic signed [RAY_W-1:0] cx, cy;

  logic signed [PROD_W-1:0] pxx, pxy, pyx, pyy, pzx, pzy;
  logic signed [COEF_W-1:0] czx, czy, czz;

  // doubled centre offset, then scale by the inverse focal length
  always_comb begin
    dx = $signed({{(D_W-DIM_W-1){1'b0}}, pixel_col, 1'b0})
       - $signed({{(D_W-CFG_DIM_W){1'b0}}, cfg.out_width});
    dy = $signed({{(D_W-DIM_W-1){1'b0}}, pixel_row, 1'b0})
       - $signed({{(D_W-CFG_DIM_W){1'b0}}, cfg.out_height});
    cx_full = dx * $signed({1'b0, cfg.inv_focal});
    cy_full = dy * $signed({1'b0, cfg.inv_focal});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: camera ray
      cx <= cx_full[RAY_W-1:0];
      cy <= cy_full[RAY_W-1:0];
      // stage 2: matrix products; the z term is a plain shift later
      pxx <= $signed(cfg.rot_row0[47:32]) * cx;
      pxy <= $signed(cfg.rot_row0[31:16]) * cy;
      pyx <= $signed(cfg.rot_row1[47:32]) * cx;
      pyy <= $signed(cfg.rot_row1[31:16]) * cy;
      pzx <= $signed(cfg.rot_row2[47:32]) * cx;
      pzy <= $signed(cfg.rot_row2[31:16]) * cy;
      czx <= $signed(cfg.rot_row0[15:0]);
      czy <= $signed(cfg.rot_row1[15:0]);
      czz <= $signed(cfg.rot_row2[15:0]);
      // stage 3: row sums
      wx <= WW'(pxx) + WW'(pxy) + (WW'(czx) <<< 31);
      wy <= WW'(pyx) + WW'(pyy) + (WW'(czy) <<< 31);
      wz <= WW'(pzx) + WW'(pzy) + (WW'(czz) <<< 31);
    end
  end

  assign out_valid = vld[2];

endmodule

/* src/e2p_norm.sv */
// Ray normalization, back-hemisphere fold and latitude gain correction.
module e2p_norm import e2p_pkg::*; #(
  parameter int WW = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [WW-1:0] wx,
  input  logic signed [WW-1:0] wy,
  input  logic signed [WW-1:0] wz,
  output logic                 out_valid,
  output cordic_t              out_d
);

  localparam int SW = $clog2(WW + 1);

  logic [3:0] vld;

  logic [WW-1:0]        mag_or;
  logic signed [WW-1:0] w1x, w1y, w1z;
  logic signed [WW-1:0] w2x, w2y, w2z;
  logic [SW-1:0]        blen, shamt;
  logic signed [WW-1:0] sxf, syf, szf;
  logic signed [NW-1:0] w3x, w3y, w3z;

  logic signed [CW-1:0]   x4, y4;
  logic signed [AW-1:0]   lon4;
  logic signed [NW+31:0]  prod4;

  function automatic logic [WW-1:0] abs_val(logic signed [WW-1:0] v);
    return v[WW-1] ? WW'(-v) : WW'(v);
  endfunction

  // bit length of the largest magnitude
  always_comb begin
    blen = '0;
    for (int i = 0; i < WW; i++) begin
      if (mag_or[i]) blen = SW'(i + 1);
    end
  end

  // shift the components back into range
  always_comb begin
    sxf = w2x >>> shamt;
    syf = w2y >>> shamt;
    szf = w2z >>> shamt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: magnitude bits
      mag_or <= abs_val(wx) | abs_val(wy) | abs_val(wz);
      w1x <= wx;
      w1y <= wy;
      w1z <= wz;
      // stage 2: shift amount
      shamt <= (blen > SW'(NORM_BITS)) ? blen - SW'(NORM_BITS) : '0;
      w2x <= w1x;
      w2y <= w1y;
      w2z <= w1z;
      // stage 3: normalized ray
      w3x <= sxf[NW-1:0];
      w3y <= syf[NW-1:0];
      w3z <= szf[NW-1:0];
      // stage 4: fold a backward ray, start longitude, correct latitude gain
      if (w3z[NW-1]) begin
        x4 <= -CW'(w3z);
        y4 <= -CW'(w3x);
        lon4 <= w3x[NW-1] ? -$signed({{(AW-32){1'b0}}, 32'h80000000})
                          :  $signed({{(AW-32){1'b0}}, 32'h80000000});
      end else begin
        x4 <= CW'(w3z);
        y4 <= CW'(w3x);
        lon4 <= '0;
      end
      prod4 <= w3y * $signed({1'b0, GAIN_Q30});
    end
  end

  always_comb begin
    out_d.x   = x4;
    out_d.y   = y4;
    out_d.ang = lon4;
    out_d.aux = CW'(prod4 >>> 30);
  end

  assign out_valid = vld[3];

endmodule

/* src/e2p_cordic_stage.sv */
// One registered vectoring CORDIC iteration.
module e2p_cordic_stage import e2p_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  cordic_t in_d,
  output logic    out_valid,
  output cordic_t out_d
);

  localparam logic signed [AW-1:0] STEP = $signed({{(AW-32){1'b0}}, ATAN_TURNS[SHIFT]});

  logic signed [CW-1:0] xs, ys;
  cordic_t nxt;

  // rotate toward the x axis
  always_comb begin
    xs = in_d.x >>> SHIFT;
    ys = in_d.y >>> SHIFT;
    nxt.aux = in_d.aux;
    if (!in_d.y[CW-1]) begin
      nxt.x   = in_d.x + ys;
      nxt.y   = in_d.y - xs;
      nxt.ang = in_d.ang + STEP;
    end else begin
      nxt.x   = in_d.x - ys;
      nxt.y   = in_d.y + xs;
      nxt.ang = in_d.ang - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= nxt;
    end
  end

endmodule

/* src/e2p_scale.sv */
// Angle clamp and scaling to panorama coordinates with rounding and saturation.
module e2p_scale import e2p_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [AW-1:0] lon,
  input  logic signed [AW-1:0] lat,
  input  logic [CFG_DIM_W-1:0] src_width,
  input  logic [CFG_DIM_W-1:0] src_height,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     src_u,
  output logic [OUT_W-1:0]     src_v
);

  localparam int SHU  = 32 - FRAC_BITS;
  localparam int SHV  = 31 - FRAC_BITS;
  localparam int UA_W = 33;
  localparam int VA_W = 32;
  localparam int PU_W = UA_W + CFG_DIM_W;
  localparam int PV_W = VA_W + CFG_DIM_W;

  localparam logic signed [AW-1:0] HALF_TURN    = $signed({{(AW-32){1'b0}}, 32'h80000000});
  localparam logic signed [AW-1:0] QUARTER_TURN = $signed({{(AW-32){1'b0}}, 32'h40000000});
  localparam logic signed [AW-1:0] FULL_TURN    = $signed({{(AW-33){1'b0}}, 33'h100000000});

  logic [1:0] vld;

  logic signed [AW-1:0] lu, lv;
  logic [UA_W-1:0]      ua;
  logic [VA_W-1:0]      va;
  logic [PU_W-1:0]      pu;
  logic [PV_W-1:0]      pv;
  logic [PU_W-1:0]      ru;
  logic [PV_W-1:0]      rv;

  // offset angles to start at zero
  always_comb begin
    lu = lon + HALF_TURN;
    lv = lat + QUARTER_TURN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: clamp to one turn and half a turn
      if (lu[AW-1])            ua <= '0;
      else if (lu > FULL_TURN) ua <= UA_W'(FULL_TURN);
      else                     ua <= UA_W'(lu);
      if (lv[AW-1])            va <= '0;
      else if (lv > HALF_TURN) va <= VA_W'(HALF_TURN);
      else                     va <= VA_W'(lv);
      // stage 2: scale to the panorama size
      pu <= PU_W'(ua) * PU_W'(src_width);
      pv <= PV_W'(va) * PV_W'(src_height);
    end
  end

  // round half up and saturate
  always_comb begin
    ru = (pu + (PU_W'(1) << (SHU - 1))) >> SHU;
    rv = (pv + (PV_W'(1) << (SHV - 1))) >> SHV;
    src_u = (ru > PU_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ru[OUT_W-1:0];
    src_v = (rv > PV_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : rv[OUT_W-1:0];
  end

  assign out_valid = vld[1];

endmodule

/* src/equirect_to_perspective_map.sv */
// Top level of the equirectangular-to-perspective coordinate map.
//
// Maps each output pixel (row, column) of a pinhole view to a fractional source
// coordinate in an equirectangular panorama. One item is accepted per clock while
// the skid stage is empty. The pipeline is made of the two chained CORDIC
// vectoring runs with one registered iteration per stage, three ray stages, four
// normalization stages, two scaling stages and the output register. A one-item
// skid stage behind the output register keeps the input open while a finished
// result waits. Configuration is written through cfg_we / cfg_index / cfg_data;
// the user must write it only while no item is in flight (not enforced).
module equirect_to_perspective_map import e2p_pkg::*; #(
  parameter int MAX_DIM_BITS  = 12,
  parameter int FRAC_BITS     = 8,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pixel_row, pixel_col, zero fill
  input  logic [((2*MAX_DIM_BITS+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // src_u, src_v, zero fill
  output logic [((2*OUT_W+7)/8)*8-1:0]      m_tdata,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);

  localparam int OUT_TW = ((2*OUT_W+7)/8)*8;
  localparam int WW     = sum_width(MAX_DIM_BITS);

  logic [CFG_DIM_W-1:0] out_width, out_height, src_width, src_height;
  logic [FOCAL_W-1:0]   inv_focal;
  logic [ROW_W-1:0]     rot_row0, rot_row1, rot_row2;
  ray_cfg_t             ray_cfg;

  logic en;

  logic                 ray_valid;
  logic signed [WW-1:0] wx, wy, wz;

  logic    lon_v [CORDIC_STAGES+1];
  cordic_t lon_d [CORDIC_STAGES+1];
  logic    lat_v [CORDIC_STAGES+1];
  cordic_t lat_d [CORDIC_STAGES+1];

  logic             f_valid;
  logic [OUT_W-1:0] f_u, f_v;

  logic                 ov, sv;
  logic [2*OUT_W-1:0]   od, sd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= 13'd1024;
      out_height <= 13'd1024;
      inv_focal  <= 32'd2097152;
      rot_row0   <= 48'h4000_0000_0000;
      rot_row1   <= 48'h0000_4000_0000;
      rot_row2   <= 48'h0000_0000_4000;
      src_width  <= 13'd2048;
      src_height <= 13'd1024;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OUT_WIDTH:  out_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_OUT_HEIGHT: out_height <= cfg_data[CFG_DIM_W-1:0];
        REG_INV_FOCAL:  inv_focal  <= cfg_data[FOCAL_W-1:0];
        REG_ROT_ROW0:   rot_row0   <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW1:   rot_row1   <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW2:   rot_row2   <= cfg_data[ROW_W-1:0];
        REG_SRC_WIDTH:  src_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ray_cfg.out_width  = out_width;
    ray_cfg.out_height = out_height;
    ray_cfg.inv_focal  = inv_focal;
    ray_cfg.rot_row0   = rot_row0;
    ray_cfg.rot_row1   = rot_row1;
    ray_cfg.rot_row2   = rot_row2;
  end

  // pipeline advances while the skid stage is empty
  assign en       = !sv;
  assign s_tready = en;

  e2p_ray #(.DIM_W(MAX_DIM_BITS)) u_ray (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .pixel_row (s_tdata[MAX_DIM_BITS-1:0]),
    .pixel_col (s_tdata[2*MAX_DIM_BITS-1:MAX_DIM_BITS]),
    .cfg       (ray_cfg),
    .out_valid (ray_valid),
    .wx        (wx),
    .wy        (wy),
    .wz        (wz)
  );

  e2p_norm #(.WW(WW)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray_valid),
    .wx        (wx),
    .wy        (wy),
    .wz        (wz),
    .out_valid (lon_v[0]),
    .out_d     (lon_d[0])
  );

  // longitude run; aux carries the gain-corrected y
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lon
    e2p_cordic_stage #(.SHIFT(i)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lon_v[i]),
      .in_d      (lon_d[i]),
      .out_valid (lon_v[i+1]),
      .out_d     (lon_d[i+1])
    );
  end

  // latitude run starts from the scaled magnitude; aux carries the longitude
  always_comb begin
    lat_v[0]     = lon_v[CORDIC_STAGES];
    lat_d[0].x   = lon_d[CORDIC_STAGES].x;
    lat_d[0].y   = lon_d[CORDIC_STAGES].aux;
    lat_d[0].ang = '0;
    lat_d[0].aux = CW'(lon_d[CORDIC_STAGES].ang);
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_lat
    e2p_cordic_stage #(.SHIFT(i)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lat_v[i]),
      .in_d      (lat_d[i]),
      .out_valid (lat_v[i+1]),
      .out_d     (lat_d[i+1])
    );
  end

  e2p_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (lat_v[CORDIC_STAGES]),
    .lon        (AW'(lat_d[CORDIC_STAGES].aux)),
    .lat        (lat_d[CORDIC_STAGES].ang),
    .src_width  (src_width),
    .src_height (src_height),
    .out_valid  (f_valid),
    .src_u      (f_u),
    .src_v      (f_v)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (en) begin
      if (ov && !m_tready) begin
        if (f_valid) begin
          sv <= 1'b1;
          ov <= 1'b1;
        end
      end else begin
        ov <= f_valid;
      end
    end else if (m_tready) begin
      sv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ov && !m_tready) begin
        if (f_valid) begin
          sd <= od;
          od <= {f_v, f_u};
        end
      end else begin
        od <= {f_v, f_u};
      end
    end
  end

  assign m_tvalid = sv || ov;
  assign m_tdata  = {{(OUT_TW-2*OUT_W){1'b0}}, (sv ? sd : od)};

`ifndef SYNTHESIS
  // skid holds an item only while a later one sits in the output register
  a_skid_behind: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry without output item");

  // skid fills only when the output item was refused
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !m_tready))
    else $error("skid filled without a stall");

  // a taken skid item frees the input side
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    sv && m_tready |=> !sv)
    else $error("skid not drained");
`endif

endmodule

/* sim/e2p_map_checker.sv */
// Checker for the equirectangular coordinate map: predicts and compares each src coordinate.
`timescale 1ns / 1ps
module e2p_map_checker import e2p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [20:0] u;
    logic [20:0] v;
  } src_coord_t;

  localparam logic [63:0] SAT_MAX = 64'h1FFFFF;

  logic [12:0] ow, oh, sw, sh;
  logic [31:0] focal;
  logic [47:0] r0, r1, r2;
  src_coord_t coord_q[$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint coef_of(logic [47:0] r, int pos);
    logic signed [15:0] c;
    c = r[pos +: 16];
    return longint'(c);
  endfunction

  function automatic longint dot3(logic [47:0] r, longint x, longint y, longint z);
    return coef_of(r, 32) * x + coef_of(r, 16) * y + coef_of(r, 0) * z;
  endfunction

  // vectoring rotation; returns angle and updates the magnitude in place
  function automatic longint vectoring(inout longint mag, input longint y, input longint ang);
    longint x, xs, ys;
    x = mag;
    for (int i = 0; i < 16; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; ang += longint'(ATAN_TURNS[i]);
      end else begin
        x -= ys; y += xs; ang -= longint'(ATAN_TURNS[i]);
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic longint clampl(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic src_coord_t map_pixel(logic [11:0] prow, logic [11:0] pcol);
    longint cx, cy, cz, wx, wy, wz, m, mag, lon, lat;
    logic [63:0] ua, va, u, v;
    int s;
    src_coord_t r;
    cx = (2 * longint'(pcol) - longint'(ow)) * longint'(focal);
    cy = (2 * longint'(prow) - longint'(oh)) * longint'(focal);
    cz = 64'sd1 <<< 31;
    wx = dot3(r0, cx, cy, cz);
    wy = dot3(r1, cx, cy, cz);
    wz = dot3(r2, cx, cy, cz);
    m = absl(wx);
    if (absl(wy) > m) m = absl(wy);
    if (absl(wz) > m) m = absl(wz);
    s = 0;
    while (s < 63 && (m >> s) >= (64'sd1 <<< 30)) s++;
    wx = fshift(wx, s);
    wy = fshift(wy, s);
    wz = fshift(wz, s);
    lon = 0;
    // ray behind the camera: start from +-pi
    if (wz < 0) begin
      lon = (wx >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      wz = -wz;
      wx = -wx;
    end
    mag = wz;
    lon = vectoring(mag, wx, lon);
    wy = fshift(wy * longint'(GAIN_Q30), 30);
    lat = vectoring(mag, wy, 0);
    ua = clampl(lon + (64'sd1 <<< 31), 64'sd1 <<< 32);
    va = clampl(lat + (64'sd1 <<< 30), 64'sd1 <<< 31);
    u = (ua * sw + (64'd1 << 23)) >> 24;
    v = (va * sh + (64'd1 << 22)) >> 23;
    if (u > SAT_MAX) u = SAT_MAX;
    if (v > SAT_MAX) v = SAT_MAX;
    r.u = u[20:0];
    r.v = v[20:0];
    return r;
  endfunction

  assign pending = coord_q.size();

  // track registers, queue predictions, compare results
  always @(posedge clk) begin
    src_coord_t exp_c;
    int bad;
    bad = 0;
    if (rst) begin
      ow <= 13'd1024; oh <= 13'd1024; focal <= 32'd2097152;
      r0 <= 48'h4000_0000_0000; r1 <= 48'h0000_4000_0000; r2 <= 48'h0000_0000_4000;
      sw <= 13'd2048; sh <= 13'd1024;
      errors <= 0;
      coord_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_OUT_WIDTH:  ow <= cfg_data[12:0];
          REG_OUT_HEIGHT: oh <= cfg_data[12:0];
          REG_INV_FOCAL:  focal <= cfg_data[31:0];
          REG_ROT_ROW0:   r0 <= cfg_data;
          REG_ROT_ROW1:   r1 <= cfg_data;
          REG_ROT_ROW2:   r2 <= cfg_data;
          REG_SRC_WIDTH:  sw <= cfg_data[12:0];
          REG_SRC_HEIGHT: sh <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        coord_q.push_back(map_pixel(s_tdata[11:0], s_tdata[23:12]));
      if (m_tvalid && m_tready) begin
        if (coord_q.size() == 0) begin
          $error("unexpected result item %h", m_tdata);
          bad++;
        end else begin
          exp_c = coord_q.pop_front();
          if (m_tdata[20:0] !== exp_c.u) begin
            $error("src_u expected %0d got %0d", exp_c.u, m_tdata[20:0]);
            bad++;
          end
          if (m_tdata[41:21] !== exp_c.v) begin
            $error("src_v expected %0d got %0d", exp_c.v, m_tdata[41:21]);
            bad++;
          end
          if (m_tdata[47:42] !== 6'd0) begin
            $error("fill expected 0 got %h", m_tdata[47:42]);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

/* sim/tb_equirect_to_perspective_map.sv */
// Testbench top for the equirectangular coordinate map: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_equirect_to_perspective_map;
  import e2p_pkg::*;

  localparam int LATENCY = 2 * 16 + 10;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  longint cycles = 0;

  always #2 clk = ~clk;

  equirect_to_perspective_map dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  e2p_map_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  // receiver stalls at the current rate
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [11:0] prow, logic [11:0] pcol);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pcol, prow};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h0000;
      3: return 16'h7FFF;
      4: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] rand_dim();
    case ($urandom_range(4))
      0: return 13'd1;
      1: return 13'd4096;
      2: return 13'd0;
      default: return 13'($urandom_range(8191));
    endcase
  endfunction

  task automatic random_cfg();
    write_reg(REG_OUT_WIDTH, 48'(rand_dim()));
    write_reg(REG_OUT_HEIGHT, 48'(rand_dim()));
    case ($urandom_range(3))
      0: write_reg(REG_INV_FOCAL, 48'hFFFF_FFFF);
      1: write_reg(REG_INV_FOCAL, 48'd0);
      default: write_reg(REG_INV_FOCAL, 48'($urandom_range(32'h0100_0000)));
    endcase
    write_reg(REG_ROT_ROW0, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(REG_ROT_ROW1, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(REG_ROT_ROW2, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(REG_SRC_WIDTH, 48'(rand_dim()));
    write_reg(REG_SRC_HEIGHT, 48'(rand_dim()));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, corners and centre
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();
    // zero matrix gives the zero ray
    write_reg(REG_ROT_ROW0, 48'd0);
    write_reg(REG_ROT_ROW1, 48'd0);
    write_reg(REG_ROT_ROW2, 48'd0);
    send_pixel(12'd100, 12'd200);
    drain();
    // ray straight back, both signs of x, wide fov for saturation
    write_reg(REG_ROT_ROW0, 48'h4000_0000_0000);
    write_reg(REG_ROT_ROW1, 48'h0000_4000_0000);
    write_reg(REG_ROT_ROW2, 48'h0000_0000_C000);
    write_reg(REG_SRC_WIDTH, 48'd4096);
    write_reg(REG_SRC_HEIGHT, 48'd4096);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd512, 12'd511);
    send_pixel(12'd512, 12'd513);
    drain();
    write_reg(REG_INV_FOCAL, 48'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();
    // zero sizes
    write_reg(REG_OUT_WIDTH, 48'd0);
    write_reg(REG_OUT_HEIGHT, 48'd0);
    write_reg(REG_SRC_WIDTH, 48'd0);
    write_reg(REG_SRC_HEIGHT, 48'd0);
    send_pixel(12'd7, 12'd9);
    drain();
    write_reg(REG_OUT_WIDTH, 48'h1FFF);
    write_reg(REG_OUT_HEIGHT, 48'h1FFF);
    write_reg(REG_SRC_WIDTH, 48'h1FFF);
    write_reg(REG_SRC_HEIGHT, 48'h1FFF);
    send_pixel(12'd4095, 12'd0);
    drain();

    // random phases with varying idle rates
    for (int ph = 0; ph < 27; ph++) begin
      if (ph < 9) begin
        send_idle = 33; recv_idle = 74;
      end else if (ph < 18) begin
        send_idle = 74; recv_idle = 33;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      random_cfg();
      for (int n = 0; n < 50; n++)
        send_pixel(12'($urandom), 12'($urandom));
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
